[sv/cbct_pkg.sv]
`timescale 1ns / 1ps

package cbct_pkg;

  // Pixel and coordinate widths
  localparam int CoordBits  = 10;
  localparam int ColorCount = 2;
  localparam int ChanW      = 8;
  localparam int ColorW     = 1;

  // Configuration register widths
  localparam int RangeW   = 6 * ChanW;
  localparam int AreaW    = 28;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = RangeW;

  // Accumulator widths: a count reaches 2^(2*CoordBits) at most
  localparam int CountW    = 2 * CoordBits + 1;
  localparam int SumW      = CountW + CoordBits;
  localparam int AreaCalcW = CountW + 8;
  localparam int DshW      = CountW + CoordBits - 1;
  localparam int StepW     = $clog2(CoordBits);

  localparam logic [CountW-1:0] CountCap = CountW'(1) << (2 * CoordBits);

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_RANGE_GO   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RANGE_STOP = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_AREA   = 2'd2;

  // Reset limits: low H,S,V in the low bytes, then high H,S,V
  localparam logic [RangeW-1:0] RangeGoReset   = 48'h6EFF_5030_D93A;
  localparam logic [RangeW-1:0] RangeStopReset = 48'hB3FF_0F5F_DD00;

  // Controller to datapath
  typedef struct packed {
    logic acc;   // accumulate the accepted pixel
    logic sel;   // pick the winner and load the dividers
    logic step;  // one quotient bit
    logic emit;  // load the result register and clear the accumulators
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic found;     // some color qualifies
    logic div_last;  // final quotient bit in progress
    logic out_free;  // result register can take a new item
  } status_t;

endpackage

[sv/cbct_pix_if.sv]
`timescale 1ns / 1ps

interface cbct_pix_if;
  logic                         valid;
  logic                         ready;
  logic [cbct_pkg::ChanW-1:0]     hue;
  logic [cbct_pkg::ChanW-1:0]     sat;
  logic [cbct_pkg::ChanW-1:0]     val;
  logic [cbct_pkg::CoordBits-1:0] col;
  logic [cbct_pkg::CoordBits-1:0] row;
  logic                         frame_end;

  modport source (output valid, hue, sat, val, col, row, frame_end, input ready);
  modport sink   (input valid, hue, sat, val, col, row, frame_end, output ready);
endinterface

[sv/cbct_res_if.sv]
`timescale 1ns / 1ps

interface cbct_res_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [cbct_pkg::ColorW-1:0]    color;
  logic [cbct_pkg::CoordBits-1:0] pos_x;
  logic [cbct_pkg::CoordBits-1:0] pos_y;
  logic [cbct_pkg::AreaW-1:0]     area;

  modport source (output valid, found, color, pos_x, pos_y, area, input ready);
  modport sink   (input valid, found, color, pos_x, pos_y, area, output ready);
endinterface

[sv/cbct_ctrl.sv]
`timescale 1ns / 1ps

module cbct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_frame_end_i,
  output logic              in_ready_o,
  output cbct_pkg::cmd_t    cmd_o,
  input  cbct_pkg::status_t status_i
);

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_SEL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Take pixels only while accumulating
  assign in_ready_o = (state_q == ST_ACC);

  // Issue commands and advance
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_ACC: begin
        cmd_o.acc = in_valid_i;
        if (in_valid_i && in_frame_end_i) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = status_i.found ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/cbct_dp.sv]
`timescale 1ns / 1ps

module cbct_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cbct_pkg::cmd_t                  cmd_i,
  output cbct_pkg::status_t               status_o,
  input  logic                            cfg_we_i,
  input  logic [cbct_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cbct_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic [cbct_pkg::ChanW-1:0]      hue_i,
  input  logic [cbct_pkg::ChanW-1:0]      sat_i,
  input  logic [cbct_pkg::ChanW-1:0]      val_i,
  input  logic [cbct_pkg::CoordBits-1:0]  col_i,
  input  logic [cbct_pkg::CoordBits-1:0]  row_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [cbct_pkg::ColorW-1:0]     color_o,
  output logic [cbct_pkg::CoordBits-1:0]  pos_x_o,
  output logic [cbct_pkg::CoordBits-1:0]  pos_y_o,
  output logic [cbct_pkg::AreaW-1:0]      area_o
);

  localparam int NCol = cbct_pkg::ColorCount;
  localparam int CW   = cbct_pkg::ChanW;

  // True when every channel lies inside the box, limits inclusive
  function automatic logic in_box(input logic [cbct_pkg::RangeW-1:0] box,
                                  input logic [CW-1:0] h,
                                  input logic [CW-1:0] s,
                                  input logic [CW-1:0] v);
    logic ok;
    ok = (h >= box[0*CW +: CW]) && (h <= box[3*CW +: CW]) &&
         (s >= box[1*CW +: CW]) && (s <= box[4*CW +: CW]) &&
         (v >= box[2*CW +: CW]) && (v <= box[5*CW +: CW]);
    return ok;
  endfunction

  // Configuration registers
  logic [cbct_pkg::RangeW-1:0] range_go_q, range_stop_q;
  logic [cbct_pkg::AreaW-1:0]  min_area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_go_q   <= cbct_pkg::RangeGoReset;
      range_stop_q <= cbct_pkg::RangeStopReset;
      min_area_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbct_pkg::REG_RANGE_GO:   range_go_q   <= cfg_wdata_i;
        cbct_pkg::REG_RANGE_STOP: range_stop_q <= cfg_wdata_i;
        cbct_pkg::REG_MIN_AREA:   min_area_q   <= cfg_wdata_i[cbct_pkg::AreaW-1:0];
        default: ;
      endcase
    end
  end

  // Per-color accumulators
  logic [cbct_pkg::CountW-1:0] count_q [NCol];
  logic [cbct_pkg::SumW-1:0]   sum_x_q [NCol];
  logic [cbct_pkg::SumW-1:0]   sum_y_q [NCol];
  logic [NCol-1:0]             hit;

  always_comb begin
    for (int c = 0; c < NCol; c++) begin
      hit[c] = in_box((c == 0) ? range_go_q : range_stop_q, hue_i, sat_i, val_i) &&
               (count_q[c] < cbct_pkg::CountCap);
    end
  end

  // Add matching pixels, clear when the frame result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCol; c++) begin
        count_q[c] <= '0;
        sum_x_q[c] <= '0;
        sum_y_q[c] <= '0;
      end
    end else if (cmd_i.emit) begin
      for (int c = 0; c < NCol; c++) begin
        count_q[c] <= '0;
        sum_x_q[c] <= '0;
        sum_y_q[c] <= '0;
      end
    end else if (cmd_i.acc) begin
      for (int c = 0; c < NCol; c++) begin
        if (hit[c]) begin
          count_q[c] <= count_q[c] + 1'b1;
          sum_x_q[c] <= sum_x_q[c] + cbct_pkg::SumW'(col_i);
          sum_y_q[c] <= sum_y_q[c] + cbct_pkg::SumW'(row_i);
        end
      end
    end
  end

  // Pick the largest area above the threshold, lower index on a tie
  logic [cbct_pkg::AreaCalcW-1:0] area_c [NCol];
  logic [cbct_pkg::AreaCalcW-1:0] best_area;
  logic                           best_found;
  logic [cbct_pkg::ColorW-1:0]    best_idx;
  logic [cbct_pkg::SumW-1:0]      sel_sum_x, sel_sum_y;
  logic [cbct_pkg::CountW-1:0]    sel_count;

  always_comb begin
    best_found = 1'b0;
    best_idx   = '0;
    best_area  = '0;
    sel_sum_x  = '0;
    sel_sum_y  = '0;
    sel_count  = '0;
    for (int c = 0; c < NCol; c++) begin
      area_c[c] = {count_q[c], 8'b0} - cbct_pkg::AreaCalcW'(count_q[c]);
      if ((area_c[c] > cbct_pkg::AreaCalcW'(min_area_q)) &&
          (!best_found || (area_c[c] > best_area))) begin
        best_found = 1'b1;
        best_idx   = cbct_pkg::ColorW'(c);
        best_area  = area_c[c];
      end
    end
    for (int c = 0; c < NCol; c++) begin
      if (best_idx == cbct_pkg::ColorW'(c)) begin
        sel_sum_x = sum_x_q[c];
        sel_sum_y = sum_y_q[c];
        sel_count = count_q[c];
      end
    end
  end

  // Winner and restoring dividers, one quotient bit per step
  logic                              win_found_q;
  logic [cbct_pkg::ColorW-1:0]       win_color_q;
  logic [cbct_pkg::AreaW-1:0]        win_area_q;
  logic [cbct_pkg::SumW-1:0]         rem_x_q, rem_y_q;
  logic [cbct_pkg::DshW-1:0]         dsh_q;
  logic [cbct_pkg::CoordBits-1:0]    quo_x_q, quo_y_q;
  logic [cbct_pkg::StepW-1:0]        step_q;
  logic                              ge_x, ge_y;

  assign ge_x = rem_x_q >= {1'b0, dsh_q};
  assign ge_y = rem_y_q >= {1'b0, dsh_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.sel) begin
      step_q <= '0;
    end else if (cmd_i.step) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      win_found_q <= best_found;
      win_color_q <= best_idx;
      win_area_q  <= best_found ? best_area[cbct_pkg::AreaW-1:0] : '0;
      rem_x_q     <= sel_sum_x;
      rem_y_q     <= sel_sum_y;
      dsh_q       <= cbct_pkg::DshW'(sel_count) << (cbct_pkg::CoordBits - 1);
      quo_x_q     <= '0;
      quo_y_q     <= '0;
    end else if (cmd_i.step) begin
      if (ge_x) begin
        rem_x_q <= rem_x_q - {1'b0, dsh_q};
      end
      if (ge_y) begin
        rem_y_q <= rem_y_q - {1'b0, dsh_q};
      end
      quo_x_q <= {quo_x_q[cbct_pkg::CoordBits-2:0], ge_x};
      quo_y_q <= {quo_y_q[cbct_pkg::CoordBits-2:0], ge_y};
      dsh_q   <= dsh_q >> 1;
    end
  end

  // Held position and color, result register
  logic [cbct_pkg::CoordBits-1:0] held_x_q, held_y_q;
  logic [cbct_pkg::ColorW-1:0]    held_color_q;
  logic                           out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_color_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (win_found_q) begin
          held_x_q     <= quo_x_q;
          held_y_q     <= quo_y_q;
          held_color_q <= win_color_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_o <= win_found_q;
      color_o <= win_found_q ? win_color_q : held_color_q;
      pos_x_o <= win_found_q ? quo_x_q : held_x_q;
      pos_y_o <= win_found_q ? quo_y_q : held_y_q;
      area_o  <= win_area_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.found    = best_found;
  assign status_o.div_last = (step_q == cbct_pkg::StepW'(cbct_pkg::CoordBits - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

[sv/color_blob_centroid_tracker.sv]
`timescale 1ns / 1ps
// Channel  Dir  Role    Payload
// pix_i    in   sink    hue, sat, val, col, row, frame_end
// res_o    out  source  found, color, pos_x, pos_y, area
// cfg_*    in   write   cfg_idx_i selects range_go, range_stop, min_area
//
// Pixels inside a frame are taken one per clock.
// The pixel marked frame_end runs through accumulate, select, ten divide steps
// and emit; with no qualifying color the divide steps are skipped.
// The frame rate is set by the shared pair of restoring dividers, one bit a cycle.
// A stalled result holds the emit step with the pixel port closed until it is
// taken. Reset clears accumulators and held values and restores the limits.

module color_blob_centroid_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbct_pix_if.sink                      pix_i,
  cbct_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [cbct_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbct_pkg::CfgDataW-1:0] cfg_wdata_i
);

  cbct_pkg::cmd_t    cmd;
  cbct_pkg::status_t status;

  cbct_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (pix_i.valid),
    .in_frame_end_i (pix_i.frame_end),
    .in_ready_o     (pix_i.ready),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  cbct_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .hue_i       (pix_i.hue),
    .sat_i       (pix_i.sat),
    .val_i       (pix_i.val),
    .col_i       (pix_i.col),
    .row_i       (pix_i.row),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .found_o     (res_o.found),
    .color_o     (res_o.color),
    .pos_x_o     (res_o.pos_x),
    .pos_y_o     (res_o.pos_y),
    .area_o      (res_o.area)
  );

`ifndef NO_ASSERTIONS
  // A frame end closes the pixel port while the result is computed
  a_frame_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready && pix_i.frame_end) |=> !pix_i.ready)
    else $error("pixel accepted right after frame end");

  // Never overwrite a result that has not been taken
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result register overwritten");

  // No qualifying color reports zero area
  a_area_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.found) |-> (res_o.area == '0))
    else $error("nonzero area without a found color");
`endif

endmodule
